@@ design/ordered_circular_deque_macros.svh @@
// Assertion macros for the ordered circular deque checker.
`ifndef ORDERED_CIRCULAR_DEQUE_MACROS_SVH
`define ORDERED_CIRCULAR_DEQUE_MACROS_SVH
// Implication checked on every clock unless in reset.
`define OCD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define OCD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/ocd_pkg.sv @@
// Shared types and codes of the ordered circular deque.
package ocd_pkg;
  typedef enum logic [3:0] {
    K_PUSH_BACK  = 4'd0,
    K_PUSH_FRONT = 4'd1,
    K_POP_BACK   = 4'd2,
    K_POP_FRONT  = 4'd3,
    K_READ       = 4'd4,
    K_WRITE      = 4'd5,
    K_CHECK      = 4'd6,
    K_SEARCH     = 4'd7,
    K_CLEAR      = 4'd8
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic signed [1:0] ORD_UP   = 2'sd1;
  localparam logic signed [1:0] ORD_DOWN = -2'sd1;
  localparam logic signed [1:0] ORD_NONE = 2'sd0;
endpackage

@@ design/ocd_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
module ocd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/ocd_front.sv @@
// Input stage: accepts items into a two-entry queue toward the engine.
module ocd_front
  import ocd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [5:0]  in_index,
  input  logic [31:0] in_value,
  input  logic [31:0] in_search_key,
  output logic        q_valid,
  input  logic        q_pop,
  output logic [3:0]  q_kind,
  output logic [5:0]  q_index,
  output logic [31:0] q_value,
  output logic [31:0] q_key
);
  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  index;
    logic [31:0] value;
    logic [31:0] key;
  } qent_t;

  qent_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_kind   = ent_r[rp_r].kind;
  assign q_index  = ent_r[rp_r].index;
  assign q_value  = ent_r[rp_r].value;
  assign q_key    = ent_r[rp_r].key;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= '{in_kind, in_index, in_value, in_search_key};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ design/ocd_back.sv @@
// Execution engine: ring store, pointers, order mark and scan sequencer.
module ocd_back
  import ocd_pkg::*;
#(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  logic [3:0]  q_kind,
  input  logic [5:0]  q_index,
  input  logic [31:0] q_value,
  input  logic [31:0] q_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [6:0]  out_found_position,
  output logic [6:0]  out_length_now,
  output logic [1:0]  out_order_state,
  output logic [1:0]  out_status
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int EW = ELEMENT_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_NB   = 6'b000100,
    S_CHK  = 6'b001000,
    S_LIN  = 6'b010000,
    S_BIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic signed [1:0] ord_r, ord_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [AW-1:0] pos_r, pos_nxt;      // logical position being fetched
  logic signed [EW-1:0] val_r, val_nxt, key_r, key_nxt, prev_r, prev_nxt;
  logic inc_r, inc_nxt, dec_r, dec_nxt;
  logic signed [CW:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic have_prev_r, have_prev_nxt;

  logic ov_r, ov_nxt;
  logic [31:0] rd_r, rd_nxt;
  logic [6:0]  fp_r, fp_nxt;
  logic [1:0]  st_r, st_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic signed [EW-1:0] cur;

  ocd_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cur = $signed(rdata);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, p};
    if (s >= CAPACITY[AW:0]) s = s - CAPACITY[AW:0];
    return s[AW-1:0];
  endfunction

  function automatic logic [CW-1:0] CapFull();
    return CW'(CAPACITY);
  endfunction

  logic out_free;
  logic [CW:0] mid_w;
  logic [CW-1:0] idx_ext;

  assign out_free = !ov_r || out_ready;
  assign idx_ext  = CW'(q_index);
  assign mid_w    = (CW+1)'((lo_nxt + hi_nxt) >>> 1);

  always_comb begin
    state_nxt = state_r;  head_nxt = head_r;  count_nxt = count_r;  ord_nxt = ord_r;
    kind_nxt = kind_r;  pos_nxt = pos_r;  val_nxt = val_r;  key_nxt = key_r;
    prev_nxt = prev_r;  inc_nxt = inc_r;  dec_nxt = dec_r;
    lo_nxt = lo_r;  hi_nxt = hi_r;  have_prev_nxt = have_prev_r;
    ov_nxt = ov_r && !out_ready;  rd_nxt = rd_r;  fp_nxt = fp_r;  st_nxt = st_r;
    q_pop = 1'b0;  we = 1'b0;  waddr = '0;  wdata = val_r[EW-1:0];  raddr = pos_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          kind_nxt = q_kind;
          val_nxt  = EW'($signed(q_value));
          key_nxt  = EW'($signed(q_key));
          rd_nxt   = '0;  fp_nxt = '1;  st_nxt = ST_OK;
          case (q_kind)
            K_PUSH_BACK, K_PUSH_FRONT: begin
              if (count_r == CapFull()) begin
                st_nxt = ST_FULL;  ov_nxt = 1'b1;
              end else if (count_r == '0 || ord_r == ORD_NONE) begin
                we = 1'b1;  wdata = val_nxt;
                if (q_kind == K_PUSH_BACK) begin
                  waddr = slot(head_r, count_r[AW-1:0]);
                end else begin
                  head_nxt = head_r - 1'b1;  waddr = head_r - 1'b1;
                  if (head_r == '0) begin
                    head_nxt = AW'(CAPACITY - 1);  waddr = AW'(CAPACITY - 1);
                  end
                end
                count_nxt = count_r + 1'b1;  ov_nxt = 1'b1;
              end else begin
                pos_nxt   = (q_kind == K_PUSH_BACK) ? AW'(count_r - 1'b1) : '0;
                state_nxt = S_RD;
              end
            end
            K_POP_BACK, K_POP_FRONT: begin
              if (count_r == '0) st_nxt = ST_EMPTY;
              else begin
                count_nxt = count_r - 1'b1;
                if (q_kind == K_POP_FRONT) head_nxt = slot(head_r, AW'(1));
              end
              ov_nxt = 1'b1;
            end
            K_READ: begin
              if (idx_ext >= count_r) begin
                st_nxt = ST_RANGE;  ov_nxt = 1'b1;
              end else begin
                pos_nxt = AW'(q_index);  state_nxt = S_RD;
              end
            end
            K_WRITE: begin
              if (idx_ext >= count_r) st_nxt = ST_RANGE;
              else begin
                we = 1'b1;  waddr = slot(head_r, AW'(q_index));  wdata = val_nxt;
              end
              ov_nxt = 1'b1;
            end
            K_CHECK: begin
              inc_nxt = 1'b1;  dec_nxt = 1'b1;  have_prev_nxt = 1'b0;
              pos_nxt = '0;
              if (count_r <= CW'(1)) begin
                ord_nxt = ORD_UP;  ov_nxt = 1'b1;
              end else begin
                state_nxt = S_RD;
              end
            end
            K_SEARCH: begin
              pos_nxt = '0;
              lo_nxt = '0;  hi_nxt = (CW+1)'(count_r) - 1'b1;
              if (count_r == '0) ov_nxt = 1'b1;
              else begin
                if (ord_r != ORD_NONE) pos_nxt = AW'(mid_w);
                state_nxt = S_RD;
              end
            end
            K_CLEAR: begin
              head_nxt = '0;  count_nxt = '0;  ord_nxt = ORD_NONE;  ov_nxt = 1'b1;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_RD: begin
        // issue read of the slot at pos_r; data returns next cycle
        raddr = slot(head_r, pos_r);
        case (kind_r)
          K_CHECK:  state_nxt = S_CHK;
          K_SEARCH: state_nxt = (ord_r == ORD_NONE) ? S_LIN : S_BIN;
          K_READ:   state_nxt = S_NB;
          default:  state_nxt = S_NB;
        endcase
      end
      S_NB: begin
        state_nxt = S_IDLE;  ov_nxt = 1'b1;
        if (kind_r == K_READ) rd_nxt = 32'($signed(cur));
        else begin
          if (kind_r == K_PUSH_BACK) begin
            if ((ord_r == ORD_UP && val_r < cur) || (ord_r == ORD_DOWN && val_r > cur))
              ord_nxt = ORD_NONE;
            we = 1'b1;  waddr = slot(head_r, count_r[AW-1:0]);
          end else begin
            if ((ord_r == ORD_UP && val_r > cur) || (ord_r == ORD_DOWN && val_r < cur))
              ord_nxt = ORD_NONE;
            we = 1'b1;
            head_nxt = head_r - 1'b1;  waddr = head_r - 1'b1;
            if (head_r == '0) begin
              head_nxt = AW'(CAPACITY - 1);  waddr = AW'(CAPACITY - 1);
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      S_CHK: begin
        if (have_prev_r) begin
          if (prev_r > cur) inc_nxt = 1'b0;
          if (prev_r < cur) dec_nxt = 1'b0;
        end
        prev_nxt = cur;  have_prev_nxt = 1'b1;
        if (CW'(pos_r) + 1'b1 >= count_r) begin
          state_nxt = S_IDLE;  ov_nxt = 1'b1;
          ord_nxt = (inc_nxt) ? ORD_UP : (dec_nxt ? ORD_DOWN : ORD_NONE);
        end else begin
          pos_nxt = pos_r + 1'b1;  state_nxt = S_RD;
        end
      end
      S_LIN: begin
        if (cur == key_r) begin
          fp_nxt = 7'(pos_r);  state_nxt = S_IDLE;  ov_nxt = 1'b1;
        end else if (CW'(pos_r) + 1'b1 >= count_r) begin
          state_nxt = S_IDLE;  ov_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;  state_nxt = S_RD;
        end
      end
      S_BIN: begin
        if (cur == key_r) begin
          fp_nxt = 7'(pos_r);  state_nxt = S_IDLE;  ov_nxt = 1'b1;
        end else begin
          if (ord_r == ORD_UP ? (cur > key_r) : (cur < key_r))
            hi_nxt = (CW+1)'(pos_r) - 1'b1;
          else
            lo_nxt = (CW+1)'(pos_r) + 1'b1;
          if (hi_nxt < lo_nxt) begin
            state_nxt = S_IDLE;  ov_nxt = 1'b1;
          end else begin
            pos_nxt = AW'(mid_w);  state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;  pos_r <= pos_nxt;  val_r <= val_nxt;  key_r <= key_nxt;
    prev_r <= prev_nxt;  inc_r <= inc_nxt;  dec_r <= dec_nxt;
    lo_r <= lo_nxt;  hi_r <= hi_nxt;  have_prev_r <= have_prev_nxt;
    rd_r <= rd_nxt;  fp_r <= fp_nxt;  st_r <= st_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;  head_r <= '0;  count_r <= '0;  ord_r <= ORD_NONE;  ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  head_r <= head_nxt;  count_r <= count_nxt;
      ord_r <= ord_nxt;  ov_r <= ov_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_read_data      = rd_r;
  assign out_found_position = fp_r;
  assign out_length_now     = 7'(count_r);
  assign out_order_state    = ord_r;
  assign out_status         = st_r;
endmodule

@@ design/ordered_circular_deque.sv @@
// Top level of the ordered circular deque.
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | kind, index, value, search_key
//   out_    | output    | out_valid / out_ready | read_data, found_position,
//           |           |                       | length_now, order_state, status
// Empty or unordered push, pop, write, clear: one item per cycle unless stalled.
// Read, and push into an ordered deque: S_RD, S_NB (registered RAM read port).
// Check-order: S_RD, S_CHK per element; search: S_RD, S_LIN per entry (linear)
// or S_RD, S_BIN per probe (binary), each step limited by the one RAM read port.
// Reset clears pointers, count and order mark; no clearing pass.
// A stalled output holds the engine; a two-entry queue takes items until full.
module ordered_circular_deque
  import ocd_pkg::*;
#(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [5:0]  in_index,
  input  logic [31:0] in_value,
  input  logic [31:0] in_search_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [6:0]  out_found_position,
  output logic [6:0]  out_length_now,
  output logic [1:0]  out_order_state,
  output logic [1:0]  out_status
);
  logic        q_valid, q_pop;
  logic [3:0]  q_kind;
  logic [5:0]  q_index;
  logic [31:0] q_value, q_key;

  ocd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_index, .in_value, .in_search_key,
    .q_valid, .q_pop, .q_kind, .q_index, .q_value, .q_key
  );

  ocd_back #(.CAPACITY(CAPACITY), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_kind, .q_index, .q_value, .q_key,
    .out_valid, .out_ready, .out_read_data, .out_found_position, .out_length_now,
    .out_order_state, .out_status
  );
endmodule

@@ design/ocd_checker.sv @@
// Port-level checks on the ordered circular deque, bound to the top level.
`include "ordered_circular_deque_macros.svh"
module ocd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_found_position,
  input logic [6:0] out_length_now,
  input logic [1:0] out_order_state,
  input logic [1:0] out_status
);
  `OCD_ASSERT_IMP(a_len_max, clk, rst_n, out_valid, out_length_now <= 7'd64, "length over capacity")
  `OCD_ASSERT_IMP(a_ord_code, clk, rst_n, out_valid, out_order_state != 2'b10, "bad order code")
  `OCD_ASSERT_IMP(a_full_len, clk, rst_n, out_valid && out_status == 2'd2,
    out_length_now == 7'd64, "full refusal below capacity")
  `OCD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_found_position), "stalled result changed")
endmodule

bind ordered_circular_deque ocd_checker u_ocd_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_found_position, .out_length_now,
  .out_order_state, .out_status
);
